@@ sv/packed_pattern_cell_unpacker_macros.svh @@
// Assertion macros for the packed pattern cell unpacker.
// No dependencies; included by the top level.
`ifndef PACKED_PATTERN_CELL_UNPACKER_MACROS_SVH
`define PACKED_PATTERN_CELL_UNPACKER_MACROS_SVH
`ifndef SYNTHESIS
`define PPCU_ASSERT(label, clk_i, rst_n_i, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (prop)) \
		else $error("assertion failed");
`else
`define PPCU_ASSERT(label, clk_i, rst_n_i, prop)
`endif
`ifndef SYNTHESIS
`define PPCU_NEXT(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PPCU_NEXT(label, clk_i, rst_n_i, ante, cons)
`endif
`endif

@@ sv/ppcu_pkg.sv @@
// Shared types, constants and the effect conversion for the cell unpacker.
// No dependencies.
package ppcu_pkg;
	localparam int MAX_ROWS_DEF = 1024;
	localparam int KEY_OFF_CODE_DEF = 121;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;
	localparam logic [7:0] KEY_OFF_BYTE = 8'h1F;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [9:0] row;
		logic [7:0] channel;
		logic       channel_out_of_range;
		logic [7:0] note;
		logic [7:0] instrument;
		logic [7:0] effect_one;
		logic [7:0] operand_one;
		logic [7:0] effect_two;
		logic [7:0] operand_two;
	} out_item_t;

	// Raw cell handed from the parser to the converter.
	typedef struct packed {
		logic [9:0]  row;
		logic [7:0]  channel;
		logic        channel_out_of_range;
		logic [7:0]  note;
		logic [7:0]  instrument;
		logic [31:0] effects;
	} raw_cell_t;

	function automatic logic [15:0] convert_effect(input logic [7:0] e_in,
			input logic [7:0] o_in);
		logic [7:0] e;
		logic [7:0] o;
		logic drop;
		logic [6:0] vol;
		logic [25:0] prod;
		e = e_in;
		o = o_in;
		drop = 1'b0;
		vol = (o_in > 8'd64) ? 7'd64 : o_in[6:0];
		prod = 26'(vol) * 26'd261120 + 26'd250;
		unique case (e_in)
			8'h00: if (o_in != 8'h00) e = 8'h20;
			8'h01: if (o_in[7:4] == 4'hF) begin e = 8'h31; o = {4'h0, o_in[3:0]}; end
			8'h02: if (o_in[7:4] == 4'hF) begin e = 8'h32; o = {4'h0, o_in[3:0]}; end
			8'h03, 8'h04, 8'h07, 8'h08, 8'h09, 8'h0B, 8'h0D, 8'h0F, 8'h11, 8'h15: ;
			8'h05, 8'h06: drop = (o_in[3:0] == 4'hF) || (o_in[7:4] == 4'hF);
			8'h0A: e = 8'h49;
			8'h0C, 8'h10: o = prod[23:16];
			8'h0E: begin
				e = 8'h30 + {4'h0, o_in[7:4]};
				o = {4'h0, o_in[3:0]};
				if (e == 8'h30 || (e >= 8'h34 && e <= 8'h37)) drop = 1'b1;
				else if (e == 8'h33) begin e = 8'h4F; o = 8'h01; end
			end
			8'h14: if (o_in == 8'h00) e = 8'h51;
			8'h1C: e = 8'h52;
			default: drop = 1'b1;
		endcase
		if (drop) begin
			e = 8'h00;
			o = 8'h00;
		end
		return {e, o};
	endfunction
endpackage

@@ sv/ppcu_parser.sv @@
// Front part: accepts packed bytes, tracks the row and assembles raw cells.
// Depends on ppcu_pkg.
module ppcu_parser import ppcu_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int KEY_OFF_CODE = KEY_OFF_CODE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_fire,
	input  in_item_t              in_item,
	output logic                  cell_valid,
	output raw_cell_t             raw_cell
);
	localparam logic [2:0] PH_PACK  = 3'd0;
	localparam logic [2:0] PH_FLAGS = 3'd1;
	localparam logic [11:0] MAX_ROWS_C = 12'(MAX_ROWS > 2047 ? 2047 : MAX_ROWS);

	logic [10:0] row_count_q;
	logic [7:0]  channel_count_q;
	logic [2:0]  phase_q;
	logic [10:0] row_q;
	logic [7:0]  chan_q;
	logic [5:0]  flags_q;
	logic [7:0]  note_q;
	logic [7:0]  instr_q;
	logic [31:0] eff_q;

	logic [10:0] limit;
	logic [5:0]  flags_n;
	logic [7:0]  note_n;
	logic [7:0]  instr_n;
	logic [31:0] eff_n;
	logic [2:0]  phase_n;
	logic        done;
	logic [2:0]  bitsel;

	assign limit = ({1'b0, row_count_q} < MAX_ROWS_C) ? row_count_q : MAX_ROWS_C[10:0];

	always_comb begin
		flags_n = flags_q;
		note_n = note_q;
		instr_n = instr_q;
		eff_n = eff_q;
		bitsel = phase_q - 3'd2;
		if (phase_q == PH_FLAGS) begin
			flags_n = in_item.data_byte[5:0];
		end else if (phase_q != PH_PACK) begin
			unique case (bitsel)
				3'd0: note_n = (in_item.data_byte == KEY_OFF_BYTE) ? 8'(KEY_OFF_CODE)
					: 8'({4'h0, in_item.data_byte[7:4]} * 8'd12
					+ {4'h0, in_item.data_byte[3:0]} + 8'd1);
				3'd1: instr_n = in_item.data_byte;
				3'd2: eff_n[7:0] = in_item.data_byte;
				3'd3: eff_n[15:8] = in_item.data_byte;
				3'd4: eff_n[23:16] = in_item.data_byte;
				3'd5: eff_n[31:24] = in_item.data_byte;
				default: ;
			endcase
			flags_n[bitsel] = 1'b0;
		end
		phase_n = PH_PACK;
		priority if (flags_n[0]) phase_n = 3'd2;
		else if (flags_n[1]) phase_n = 3'd3;
		else if (flags_n[2]) phase_n = 3'd4;
		else if (flags_n[3]) phase_n = 3'd5;
		else if (flags_n[4]) phase_n = 3'd6;
		else if (flags_n[5]) phase_n = 3'd7;
		else phase_n = PH_PACK;
		done = (phase_q != PH_PACK) && (flags_n == 6'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 11'd64;
			channel_count_q <= 8'd4;
		end else if (cfg_we) begin
			if (cfg_index == REG_ROW_COUNT) row_count_q <= cfg_data;
			else channel_count_q <= cfg_data[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_cell.row <= row_q[9:0];
			raw_cell.channel <= chan_q;
			raw_cell.channel_out_of_range <= chan_q >= channel_count_q;
			raw_cell.note <= note_n;
			raw_cell.instrument <= instr_n;
			raw_cell.effects <= eff_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PACK;
			row_q <= '0;
			chan_q <= '0;
			flags_q <= '0;
			note_q <= '0;
			instr_q <= '0;
			eff_q <= '0;
			cell_valid <= 1'b0;
		end else begin
			cell_valid <= in_fire && done;
			if (in_fire) begin
				if (in_item.last_byte) begin
					phase_q <= PH_PACK;
					row_q <= '0;
					chan_q <= '0;
					flags_q <= '0;
					note_q <= '0;
					instr_q <= '0;
					eff_q <= '0;
				end else if (phase_q == PH_PACK) begin
					if (row_q < limit) begin
						if (in_item.data_byte == 8'h00) begin
							row_q <= row_q + 11'd1;
						end else begin
							chan_q <= in_item.data_byte - 8'd1;
							note_q <= '0;
							instr_q <= '0;
							eff_q <= '0;
							flags_q <= '0;
							phase_q <= PH_FLAGS;
						end
					end
				end else begin
					flags_q <= flags_n;
					note_q <= note_n;
					instr_q <= instr_n;
					eff_q <= eff_n;
					phase_q <= phase_n;
				end
			end
		end
	end
endmodule

@@ sv/ppcu_queue.sv @@
// Short queue between the parser and the converter.
// Depends on ppcu_pkg.
module ppcu_queue import ppcu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  raw_cell_t push_data,
	input  logic      pop,
	output logic      not_empty,
	output logic      almost_full,
	output raw_cell_t head
);
	raw_cell_t  mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;

	assign not_empty = cnt_q != 3'd0;
	assign almost_full = cnt_q >= 3'd2;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule

@@ sv/ppcu_convert.sv @@
// Back part: converts effects and holds the result in an output register.
// Depends on ppcu_pkg.
module ppcu_convert import ppcu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cell_avail,
	input  raw_cell_t raw_cell,
	output logic      cell_pop,
	output logic      valid,
	input  logic      stall,
	output out_item_t data
);
	logic [15:0] c1;
	logic [15:0] c2;

	assign cell_pop = cell_avail && (!valid || !stall);
	assign c1 = convert_effect(raw_cell.effects[7:0], raw_cell.effects[15:8]);
	assign c2 = convert_effect(raw_cell.effects[23:16], raw_cell.effects[31:24]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (!valid || !stall) begin
			valid <= cell_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_pop) begin
			data.row <= raw_cell.row;
			data.channel <= raw_cell.channel;
			data.channel_out_of_range <= raw_cell.channel_out_of_range;
			data.note <= raw_cell.note;
			data.instrument <= raw_cell.instrument;
			data.effect_one <= c1[15:8];
			data.operand_one <= c1[7:0];
			data.effect_two <= c2[15:8];
			data.operand_two <= c2[7:0];
		end
	end
endmodule

@@ sv/packed_pattern_cell_unpacker.sv @@
// Top level of the packed pattern cell unpacker.
// Depends on ppcu_pkg, ppcu_parser, ppcu_queue, ppcu_convert and the macro header.
// Usage: bytes of packed pattern data enter on in_valid/in_stall/in_data, one
// transaction per byte. Decoded cells leave on out_valid/out_stall/out_data.
// While in_stall is low the parser takes one byte every cycle and writes each
// finished cell into a four-entry queue in the next cycle. The converter
// remaps the two effect pairs and loads the output register, so a cell passes
// the parser register, the queue and the output register in that order.
// in_stall rises when the queue holds two or more cells; the slack covers the
// cell still in the parser register. When the receiver stalls, the output
// register holds its transaction and the queue fills behind it.
// Reset clears the parser to expect a pack byte at row zero, empties the queue
// and sets row_count to 64 and channel_count to 4. The user must ensure that
// configuration is written through cfg_we/cfg_index/cfg_data only while the
// block is idle, which is not enforced. A last_byte byte clears the parse state.
`include "packed_pattern_cell_unpacker_macros.svh"
module packed_pattern_cell_unpacker import ppcu_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int KEY_OFF_CODE = KEY_OFF_CODE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);
	logic      in_fire;
	logic      cell_valid_s1;
	raw_cell_t cell_s1;
	logic      q_not_empty;
	logic      q_almost_full;
	raw_cell_t q_head;
	logic      q_pop;

	assign in_fire = in_valid && !in_stall;
	assign in_stall = q_almost_full;

	ppcu_parser #(.MAX_ROWS(MAX_ROWS), .KEY_OFF_CODE(KEY_OFF_CODE)) u_parser (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_fire, .in_item(in_data),
		.cell_valid(cell_valid_s1), .raw_cell(cell_s1)
	);

	ppcu_queue u_queue (
		.clk, .arst_n, .push(cell_valid_s1), .push_data(cell_s1),
		.pop(q_pop), .not_empty(q_not_empty), .almost_full(q_almost_full),
		.head(q_head)
	);

	ppcu_convert u_convert (
		.clk, .arst_n, .cell_avail(q_not_empty), .raw_cell(q_head),
		.cell_pop(q_pop), .valid(out_valid), .stall(out_stall), .data(out_data)
	);

	// The queue never pops while empty.
	`PPCU_ASSERT(a_no_underflow, clk, arst_n, !q_pop || q_not_empty)
	// A stalled result stays in place.
	`PPCU_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data))
	// No cell is produced without a byte accepted the cycle before.
	`PPCU_NEXT(a_cell_src, clk, arst_n, !in_fire, !cell_valid_s1)
endmodule
